@@ rtl/register_file_alu_with_compare_flags_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the register file ALU core
// Shared property forms used by the checker of the register file ALU core.
// ----------------------------------------------------------------------------
`ifndef REGISTER_FILE_ALU_WITH_COMPARE_FLAGS_CORE_ASSERT_SVH
`define REGISTER_FILE_ALU_WITH_COMPARE_FLAGS_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and quiet during reset.
`define RFAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and quiet during reset.
`define RFAC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rfac_pkg.sv @@
// ----------------------------------------------------------------------------
// Register file ALU package
// Item types, function codes and the internal operation classes.
// ----------------------------------------------------------------------------
package rfac_pkg;

  localparam logic [3:0] FUNC_CMP  = 4'd0;
  localparam logic [3:0] FUNC_ADD  = 4'd1;
  localparam logic [3:0] FUNC_SUB  = 4'd2;
  localparam logic [3:0] FUNC_AND  = 4'd3;
  localparam logic [3:0] FUNC_OR   = 4'd4;
  localparam logic [3:0] FUNC_XOR  = 4'd5;
  localparam logic [3:0] FUNC_SHL  = 4'd6;
  localparam logic [3:0] FUNC_SHR  = 4'd7;
  localparam logic [3:0] FUNC_LOAD = 4'd8;

  localparam int unsigned IndexW     = 5;
  localparam int unsigned DataW      = 32;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [3:0] {
    OP_CMP,
    OP_ADD,
    OP_SUB,
    OP_AND,
    OP_OR,
    OP_XOR,
    OP_SHL,
    OP_SHR,
    OP_LOAD,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [3:0]        func;
    logic [IndexW-1:0] dest_index;
    logic [IndexW-1:0] src_index;
    logic [4:0]        shift_amount;
    logic [DataW-1:0]  load_value;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] old_dest_value;
    logic [DataW-1:0] second_operand;
    logic [DataW-1:0] new_dest_value;
    logic             flag_greater;
    logic             flag_less;
    logic             flag_equal;
  } out_item_t;

  typedef struct packed {
    op_e              op;
    logic [4:0]       shift_amount;
    logic [DataW-1:0] load_value;
  } cmd_t;

endpackage

@@ rtl/rfac_front.sv @@
// ----------------------------------------------------------------------------
// Register file ALU front end
// Accepts items, classifies the function code and maps indexes to bank slots.
// ----------------------------------------------------------------------------
module rfac_front #(
  parameter int unsigned RegCount = 32,
  parameter int unsigned SlotW    = 5
) (
  input  logic               in_valid_i,
  input  rfac_pkg::in_item_t in_item_i,
  input  logic               q_full_i,
  output logic               in_stall_o,
  output logic               push_o,
  output rfac_pkg::cmd_t     cmd_o,
  output logic [SlotW-1:0]   x_slot_o,
  output logic [SlotW-1:0]   y_slot_o
);

  localparam int unsigned IndexCount = 1 << rfac_pkg::IndexW;

  logic [SlotW-1:0] slot_tbl [IndexCount];

  for (genvar g = 0; g < IndexCount; g++) begin : g_slot
    assign slot_tbl[g] = SlotW'(g % RegCount);
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign x_slot_o   = slot_tbl[in_item_i.dest_index];
  assign y_slot_o   = slot_tbl[in_item_i.src_index];

  always_comb begin
    cmd_o.shift_amount = in_item_i.shift_amount;
    cmd_o.load_value   = in_item_i.load_value;
    case (in_item_i.func)
      rfac_pkg::FUNC_CMP:  cmd_o.op = rfac_pkg::OP_CMP;
      rfac_pkg::FUNC_ADD:  cmd_o.op = rfac_pkg::OP_ADD;
      rfac_pkg::FUNC_SUB:  cmd_o.op = rfac_pkg::OP_SUB;
      rfac_pkg::FUNC_AND:  cmd_o.op = rfac_pkg::OP_AND;
      rfac_pkg::FUNC_OR:   cmd_o.op = rfac_pkg::OP_OR;
      rfac_pkg::FUNC_XOR:  cmd_o.op = rfac_pkg::OP_XOR;
      rfac_pkg::FUNC_SHL:  cmd_o.op = rfac_pkg::OP_SHL;
      rfac_pkg::FUNC_SHR:  cmd_o.op = rfac_pkg::OP_SHR;
      rfac_pkg::FUNC_LOAD: cmd_o.op = rfac_pkg::OP_LOAD;
      default:             cmd_o.op = rfac_pkg::OP_NOP;
    endcase
  end

endmodule

@@ rtl/rfac_queue.sv @@
// ----------------------------------------------------------------------------
// Register file ALU command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module rfac_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [Width-1:0] head_o
);

  localparam int unsigned PtrW = $clog2(rfac_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(rfac_pkg::QueueDepth + 1);

  logic [Width-1:0] entry_q [rfac_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(rfac_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/rfac_back.sv @@
// ----------------------------------------------------------------------------
// Register file ALU back end
// Reads the register bank, executes one command, writes back and drives the
// output register. A bypass covers the write that lands in the read cycle.
// ----------------------------------------------------------------------------
module rfac_back #(
  parameter int unsigned RegCount = 32,
  parameter int unsigned SlotW    = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  rfac_pkg::cmd_t      q_cmd_i,
  input  logic [SlotW-1:0]    q_x_slot_i,
  input  logic [SlotW-1:0]    q_y_slot_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rfac_pkg::out_item_t out_item_o
);

  localparam int unsigned DataW = rfac_pkg::DataW;

  logic [DataW-1:0]    bank_q [RegCount];
  logic [RegCount-1:0] written_q;

  logic                ex_valid_q, ex_valid_d;
  rfac_pkg::cmd_t      ex_cmd_q;
  logic [SlotW-1:0]    ex_x_q;
  logic [DataW-1:0]    rd_x_q, rd_y_q;
  logic                wr_x_q, wr_y_q;
  logic                byp_x_q, byp_y_q;
  logic [DataW-1:0]    byp_data_q;
  logic [2:0]          flags_q, flags_d;
  logic                out_valid_q, out_valid_d;
  rfac_pkg::out_item_t out_item_q;

  logic             ex_fire;
  logic             ex_free;
  logic [DataW-1:0] xv, yv, res, second;

  assign ex_fire = ex_valid_q && (!out_valid_q || !out_stall_i);
  assign ex_free = !ex_valid_q || ex_fire;
  assign q_pop_o = q_valid_i && ex_free;

  assign xv = byp_x_q ? byp_data_q : (wr_x_q ? rd_x_q : '0);
  assign yv = byp_y_q ? byp_data_q : (wr_y_q ? rd_y_q : '0);

  always_comb begin
    res     = xv;
    second  = yv;
    flags_d = flags_q;
    case (ex_cmd_q.op)
      rfac_pkg::OP_CMP: begin
        if ($signed(xv) > $signed(yv)) begin
          flags_d = 3'b100;
        end else if ($signed(xv) < $signed(yv)) begin
          flags_d = 3'b010;
        end else begin
          flags_d = 3'b001;
        end
      end
      rfac_pkg::OP_ADD:  res = xv + yv;
      rfac_pkg::OP_SUB:  res = xv - yv;
      rfac_pkg::OP_AND:  res = xv & yv;
      rfac_pkg::OP_OR:   res = xv | yv;
      rfac_pkg::OP_XOR:  res = xv ^ yv;
      rfac_pkg::OP_SHL: begin
        res    = xv << ex_cmd_q.shift_amount;
        second = DataW'(ex_cmd_q.shift_amount);
      end
      rfac_pkg::OP_SHR: begin
        res    = xv >> ex_cmd_q.shift_amount;
        second = DataW'(ex_cmd_q.shift_amount);
      end
      rfac_pkg::OP_LOAD: res = ex_cmd_q.load_value;
      default: ;
    endcase
  end

  always_comb begin
    ex_valid_d = ex_valid_q;
    if (q_pop_o) begin
      ex_valid_d = 1'b1;
    end else if (ex_fire) begin
      ex_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (ex_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
      written_q   <= '0;
      byp_x_q     <= 1'b0;
      byp_y_q     <= 1'b0;
    end else begin
      ex_valid_q  <= ex_valid_d;
      out_valid_q <= out_valid_d;
      if (ex_fire) begin
        flags_q            <= flags_d;
        written_q[ex_x_q]  <= 1'b1;
      end
      if (q_pop_o) begin
        byp_x_q <= ex_fire && (ex_x_q == q_x_slot_i);
        byp_y_q <= ex_fire && (ex_x_q == q_y_slot_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      bank_q[ex_x_q] <= res;
    end
    if (q_pop_o) begin
      rd_x_q     <= bank_q[q_x_slot_i];
      rd_y_q     <= bank_q[q_y_slot_i];
      wr_x_q     <= written_q[q_x_slot_i];
      wr_y_q     <= written_q[q_y_slot_i];
      byp_data_q <= res;
      ex_cmd_q   <= q_cmd_i;
      ex_x_q     <= q_x_slot_i;
    end
    if (ex_fire) begin
      out_item_q.old_dest_value <= xv;
      out_item_q.second_operand <= second;
      out_item_q.new_dest_value <= res;
      out_item_q.flag_greater   <= flags_d[2];
      out_item_q.flag_less      <= flags_d[1];
      out_item_q.flag_equal     <= flags_d[0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ rtl/register_file_alu_with_compare_flags_core.sv @@
// ----------------------------------------------------------------------------
// Register file ALU core with compare flags
// Executes one two-operand instruction per item on a bank of 32-bit
// registers and reports the old and new destination values and the flags.
// ----------------------------------------------------------------------------
// The core takes one item per clock cycle while the output is not stalled,
// and delivers one result item for each, in order. An accepted item passes
// the command queue, whose pop also registers the bank read, and then the
// execute stage that writes the bank back and loads the output register.
// The single read-modify-write execute stage, with a bypass for the write
// that lands in the read cycle, sets the rate of one item per cycle. The bank
// reads as all zero at once after reset, so items are taken right away.
module register_file_alu_with_compare_flags_core #(
  parameter int unsigned REG_COUNT = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rfac_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rfac_pkg::out_item_t out_item_o
);

  localparam int unsigned SlotW  = $clog2(REG_COUNT);
  localparam int unsigned QWidth = $bits(rfac_pkg::cmd_t) + 2 * SlotW;

  logic               q_full, q_push, q_pop, q_valid;
  rfac_pkg::cmd_t     f_cmd, b_cmd;
  logic [SlotW-1:0]   f_x_slot, f_y_slot, b_x_slot, b_y_slot;
  logic [QWidth-1:0]  q_head;

  rfac_front #(
    .RegCount(REG_COUNT),
    .SlotW   (SlotW)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .in_stall_o(in_stall_o),
    .push_o    (q_push),
    .cmd_o     (f_cmd),
    .x_slot_o  (f_x_slot),
    .y_slot_o  (f_y_slot)
  );

  rfac_queue #(
    .Width(QWidth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i({f_cmd, f_x_slot, f_y_slot}),
    .pop_i      (q_pop),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  assign {b_cmd, b_x_slot, b_y_slot} = q_head;

  rfac_back #(
    .RegCount(REG_COUNT),
    .SlotW   (SlotW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (b_cmd),
    .q_x_slot_i (b_x_slot),
    .q_y_slot_i (b_y_slot),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

@@ rtl/rfac_checker.sv @@
// ----------------------------------------------------------------------------
// Register file ALU checker
// Watches core ports for output stability, flag consistency and idle stalls.
// ----------------------------------------------------------------------------
`include "register_file_alu_with_compare_flags_core_assert.svh"

module rfac_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_i,
  input logic                out_valid_i,
  input logic                out_stall_i,
  input rfac_pkg::out_item_t out_item_i
);

  logic [2:0] flags;
  logic       any_flag;

  assign flags    = {out_item_i.flag_greater, out_item_i.flag_less, out_item_i.flag_equal};
  assign any_flag = out_item_i.flag_greater || out_item_i.flag_less || out_item_i.flag_equal;

  `RFAC_ASSERT_IMP(a_flags_onehot, out_valid_i, $onehot0(flags), "more than one flag set")

  `RFAC_ASSERT_IMP(a_flags_sticky, (out_valid_i && !out_stall_i && any_flag ##1 out_valid_i),
                   any_flag, "flags cleared after a compare")

  `RFAC_ASSERT_NXT(a_out_hold, out_valid_i && out_stall_i,
                   out_valid_i && $stable(out_item_i), "stalled result changed")

  `RFAC_ASSERT_NXT(a_no_stall_when_idle, !in_valid_i && !out_valid_i && !in_stall_i,
                   !in_stall_i, "input stalled with nothing in flight")

endmodule

bind register_file_alu_with_compare_flags_core rfac_checker u_rfac_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_i (in_stall_o),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_i (out_item_o)
);

@@ sim/tb_register_file_alu_with_compare_flags_core.sv @@
// ----------------------------------------------------------------------------
// Testbench for the register file ALU core with compare flags
// Drives directed and random instructions through the valid/stall channels
// under several idle and stall patterns, predicts each result item from a
// local copy of the register bank and flags, and checks every field.
// ----------------------------------------------------------------------------
module tb_register_file_alu_with_compare_flags_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DataW          = rfac_pkg::DataW;
  localparam int unsigned REG_COUNT      = 32;
  localparam time         CLK_PERIOD     = 20ns;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned IDLE_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned PHASE_ITEMS    = 166;
  localparam int unsigned PHASE_COUNT    = 8;
  localparam logic [3:0]  FUNC_UNUSED_LO = rfac_pkg::FUNC_LOAD + 4'd1;
  localparam logic [3:0]  FUNC_UNUSED_HI = 4'hF;

  class alu_result_tracker;
    logic [DataW-1:0]    bank [REG_COUNT];
    logic                greater;
    logic                less;
    logic                equal;
    rfac_pkg::out_item_t pending_results [$];
    int unsigned         mismatches;

    function new();
      foreach (bank[i]) bank[i] = '0;
      greater     = 1'b0;
      less        = 1'b0;
      equal       = 1'b0;
      mismatches  = 0;
    endfunction

    function int unsigned pending_count();
      return pending_results.size();
    endfunction

    function void note_instruction(rfac_pkg::in_item_t it);
      int unsigned         xi;
      int unsigned         yi;
      logic [DataW-1:0]    xv;
      logic [DataW-1:0]    yv;
      logic [DataW-1:0]    res;
      logic [DataW-1:0]    second;
      rfac_pkg::out_item_t outcome;
      xi     = it.dest_index % REG_COUNT;
      yi     = it.src_index % REG_COUNT;
      xv     = bank[xi];
      yv     = bank[yi];
      res    = xv;
      second = yv;
      case (it.func)
        rfac_pkg::FUNC_CMP: begin
          greater = $signed(xv) > $signed(yv);
          less    = $signed(xv) < $signed(yv);
          equal   = (xv == yv);
        end
        rfac_pkg::FUNC_ADD:  res = xv + yv;
        rfac_pkg::FUNC_SUB:  res = xv - yv;
        rfac_pkg::FUNC_AND:  res = xv & yv;
        rfac_pkg::FUNC_OR:   res = xv | yv;
        rfac_pkg::FUNC_XOR:  res = xv ^ yv;
        rfac_pkg::FUNC_SHL: begin
          res    = xv << it.shift_amount;
          second = DataW'(it.shift_amount);
        end
        rfac_pkg::FUNC_SHR: begin
          res    = xv >> it.shift_amount;
          second = DataW'(it.shift_amount);
        end
        rfac_pkg::FUNC_LOAD: res = it.load_value;
        default: ;
      endcase
      bank[xi] = res;
      outcome.old_dest_value = xv;
      outcome.second_operand = second;
      outcome.new_dest_value = res;
      outcome.flag_greater   = greater;
      outcome.flag_less      = less;
      outcome.flag_equal     = equal;
      pending_results.push_back(outcome);
    endfunction

    function void report(string what, logic [DataW-1:0] wanted, logic [DataW-1:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("%0t: mismatch in %s: expected %h, got %h", $time, what, wanted, got);
      end
    endfunction

    function void check_result(rfac_pkg::out_item_t got);
      rfac_pkg::out_item_t wanted;
      if (pending_results.size() == 0) begin
        report("result with none expected", '0, got.new_dest_value);
        return;
      end
      wanted = pending_results.pop_front();
      if (got.old_dest_value !== wanted.old_dest_value) begin
        report("old_dest_value", wanted.old_dest_value, got.old_dest_value);
      end
      if (got.second_operand !== wanted.second_operand) begin
        report("second_operand", wanted.second_operand, got.second_operand);
      end
      if (got.new_dest_value !== wanted.new_dest_value) begin
        report("new_dest_value", wanted.new_dest_value, got.new_dest_value);
      end
      if (got.flag_greater !== wanted.flag_greater) begin
        report("flag_greater", DataW'(wanted.flag_greater), DataW'(got.flag_greater));
      end
      if (got.flag_less !== wanted.flag_less) begin
        report("flag_less", DataW'(wanted.flag_less), DataW'(got.flag_less));
      end
      if (got.flag_equal !== wanted.flag_equal) begin
        report("flag_equal", DataW'(wanted.flag_equal), DataW'(got.flag_equal));
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  rfac_pkg::in_item_t  in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  rfac_pkg::out_item_t out_item_o;

  alu_result_tracker tracker = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          stimulus_done = 1'b0;
  int unsigned idle_cycles = 0;

  register_file_alu_with_compare_flags_core #(
    .REG_COUNT(REG_COUNT)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic rfac_pkg::in_item_t make_instruction(logic [3:0] func, logic [4:0] x,
                                                          logic [4:0] y, logic [4:0] sh,
                                                          logic [DataW-1:0] value);
    rfac_pkg::in_item_t it;
    it.func         = func;
    it.dest_index   = x;
    it.src_index    = y;
    it.shift_amount = sh;
    it.load_value   = value;
    return it;
  endfunction

  function automatic rfac_pkg::in_item_t random_instruction();
    rfac_pkg::in_item_t it;
    int unsigned        pick;
    int unsigned        top_index;
    top_index = ($urandom_range(1) == 0) ? 3 : 31;
    pick      = $urandom_range(99);
    if (pick < 15) begin
      it.func = rfac_pkg::FUNC_LOAD;
    end else if (pick < 95) begin
      it.func = 4'($urandom_range(rfac_pkg::FUNC_SHR, rfac_pkg::FUNC_CMP));
    end else begin
      it.func = 4'($urandom_range(FUNC_UNUSED_HI, FUNC_UNUSED_LO));
    end
    it.dest_index   = 5'($urandom_range(top_index));
    it.src_index    = 5'($urandom_range(top_index));
    it.shift_amount = 5'($urandom_range(31));
    case ($urandom_range(7))
      0:       it.load_value = 32'h0000_0000;
      1:       it.load_value = 32'hFFFF_FFFF;
      2:       it.load_value = 32'h8000_0000;
      3:       it.load_value = 32'h7FFF_FFFF;
      default: it.load_value = $urandom;
    endcase
    return it;
  endfunction

  task automatic drive_instruction(rfac_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_instruction(it);
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pending_count() != 0) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni === 1'b1) begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_result(out_item_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (!stimulus_done || tracker.pending_count() != 0) begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= IDLE_LIMIT) begin
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    drive_instruction(make_instruction(rfac_pkg::FUNC_LOAD, 5'd0, 5'd31, 5'd31, 32'h7FFF_FFFF));
    drive_instruction(make_instruction(rfac_pkg::FUNC_LOAD, 5'd1, 5'd0, 5'd0, 32'h8000_0000));
    drive_instruction(make_instruction(rfac_pkg::FUNC_LOAD, 5'd2, 5'd1, 5'd0, 32'hFFFF_FFFF));
    drive_instruction(make_instruction(rfac_pkg::FUNC_LOAD, 5'd31, 5'd2, 5'd0, 32'h0000_0001));
    drive_instruction(make_instruction(rfac_pkg::FUNC_CMP, 5'd0, 5'd1, 5'd0, 32'h0));
    drive_instruction(make_instruction(rfac_pkg::FUNC_CMP, 5'd1, 5'd0, 5'd0, 32'h0));
    drive_instruction(make_instruction(rfac_pkg::FUNC_CMP, 5'd2, 5'd2, 5'd0, 32'h0));
    drive_instruction(make_instruction(rfac_pkg::FUNC_CMP, 5'd3, 5'd2, 5'd0, 32'h0));
    drive_instruction(make_instruction(rfac_pkg::FUNC_ADD, 5'd0, 5'd31, 5'd0, 32'h0));
    drive_instruction(make_instruction(rfac_pkg::FUNC_ADD, 5'd2, 5'd31, 5'd0, 32'h0));
    drive_instruction(make_instruction(rfac_pkg::FUNC_SUB, 5'd3, 5'd31, 5'd0, 32'h0));
    drive_instruction(make_instruction(rfac_pkg::FUNC_SUB, 5'd1, 5'd1, 5'd0, 32'h0));
    drive_instruction(make_instruction(rfac_pkg::FUNC_LOAD, 5'd4, 5'd5, 5'd0, 32'hA5A5_A5A5));
    drive_instruction(make_instruction(rfac_pkg::FUNC_LOAD, 5'd5, 5'd4, 5'd0, 32'h5A5A_5A5A));
    drive_instruction(make_instruction(rfac_pkg::FUNC_OR, 5'd5, 5'd4, 5'd0, 32'h0));
    drive_instruction(make_instruction(rfac_pkg::FUNC_AND, 5'd4, 5'd5, 5'd0, 32'h0));
    drive_instruction(make_instruction(rfac_pkg::FUNC_XOR, 5'd5, 5'd5, 5'd0, 32'h0));
    drive_instruction(make_instruction(rfac_pkg::FUNC_SHL, 5'd31, 5'd3, 5'd31, 32'h0));
    drive_instruction(make_instruction(rfac_pkg::FUNC_SHR, 5'd31, 5'd3, 5'd31, 32'h0));
    drive_instruction(make_instruction(rfac_pkg::FUNC_SHL, 5'd3, 5'd0, 5'd0, 32'h0));
    drive_instruction(make_instruction(rfac_pkg::FUNC_SHR, 5'd3, 5'd0, 5'd1, 32'h0));
    drive_instruction(make_instruction(FUNC_UNUSED_LO, 5'd0, 5'd1, 5'd7, 32'h1234_5678));
    drive_instruction(make_instruction(FUNC_UNUSED_HI, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF));
    drive_instruction(make_instruction(rfac_pkg::FUNC_CMP, 5'd31, 5'd0, 5'd0, 32'h0));

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      if (phase == PHASE_COUNT / 2) begin
        wait_for_drain();
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        drive_instruction(random_instruction());
      end
    end

    wait_for_drain();
    stimulus_done = 1'b1;
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_count() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/rfac_pkg.sv
rtl/rfac_front.sv
rtl/rfac_queue.sv
rtl/rfac_back.sv
rtl/register_file_alu_with_compare_flags_core.sv
rtl/rfac_checker.sv
sim/tb_register_file_alu_with_compare_flags_core.sv
